>>> hdl/esc_pkg.sv
// ============================================================================
// Environmental sensor compensation package
// Shared register indexes, constants and shift helpers for the compensation
// datapath.
// ============================================================================
package esc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CAL_TEMP_P9   = 3'd0,
    REG_CAL_PRESS_LO  = 3'd1,
    REG_CAL_PRESS_HI  = 3'd2,
    REG_CAL_HUM       = 3'd3,
    REG_TEMP_LIMIT    = 3'd4,
    REG_PRESS_LIMIT   = 3'd5,
    REG_HUM_LIMIT     = 3'd6,
    REG_UNUSED        = 3'd7
  } esc_reg_t;

  // Reset values of the alarm limits.
  localparam logic [14:0] TEMP_LIMIT_RST  = 15'd2500;
  localparam logic [10:0] PRESS_LIMIT_RST = 11'd960;
  localparam logic [6:0]  HUM_LIMIT_RST   = 7'd70;

  // Compensation constants.
  localparam logic [33:0] T_FINE_OFS_P    = 34'd128000;
  localparam logic [31:0] T_FINE_OFS_H    = 32'd76800;
  localparam logic [63:0] P_BIAS          = 64'h0000_8000_0000_0000;
  localparam logic [63:0] P_FULL_SCALE    = 64'd1048576;
  localparam logic [63:0] P_SCALE         = 64'd3125;
  localparam logic [31:0] H_MAX           = 32'd419430400;
  localparam logic [31:0] H_OFS_Y         = 32'd2097152;

  // Reciprocal of 100 in Q32, exact for 24-bit dividends.
  localparam logic [25:0] RECIP_100       = 26'd42949673;

  // Divider depth: one quotient bit per stage.
  localparam int unsigned DIV_STAGES      = 64;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
    asr32 = 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
    asr64 = 64'($signed(x) >>> s);
  endfunction

endpackage

>>> hdl/env_sensor_compensate_unit.sv
// ============================================================================
// Environmental sensor compensation unit
// Pipelined fixed-point compensation of raw temperature, pressure and
// humidity samples with threshold alarms.
// ============================================================================
//
//  Channel | Signals                                    | Direction
//  --------+--------------------------------------------+----------
//  input   | start, busy, in_raw_temp/press/hum         | in/out
//  result  | out_valid, out_temp_centi ... out_hum_alarm| out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | in/out
//
//  One sample enters in every cycle; busy stays low.
//  The pipeline has 11 datapath stages, a 64-stage restoring divider
//  (one quotient bit per stage) and 5 output stages.
//  Reset clears the valid line and loads the register reset values.
//  The result is shown for one cycle under out_valid; nothing stalls.
//
module env_sensor_compensate_unit
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input beats
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_raw_temp,
  input  logic [19:0] in_raw_press,
  input  logic [15:0] in_raw_hum,
  // Result beats
  output logic        out_valid,
  output logic [31:0] out_temp_centi,
  output logic [31:0] out_press_q24_8,
  output logic [17:0] out_press_hpa,
  output logic [16:0] out_hum_q22_10,
  output logic        out_temp_alarm,
  output logic        out_press_alarm,
  output logic        out_hum_alarm,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0] cal_t_r, cal_pl_r, cal_ph_r, cal_h_r;
  logic [14:0] temp_lim_r;
  logic [10:0] press_lim_r;
  logic [6:0]  hum_lim_r;
  esc_reg_t    cfg_sel;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign cfg_sel   = esc_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t_r     <= '0;
      cal_pl_r    <= '0;
      cal_ph_r    <= '0;
      cal_h_r     <= '0;
      temp_lim_r  <= TEMP_LIMIT_RST;
      press_lim_r <= PRESS_LIMIT_RST;
      hum_lim_r   <= HUM_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_sel)
        REG_CAL_TEMP_P9:  cal_t_r     <= cfg_data;
        REG_CAL_PRESS_LO: cal_pl_r    <= cfg_data;
        REG_CAL_PRESS_HI: cal_ph_r    <= cfg_data;
        REG_CAL_HUM:      cal_h_r     <= cfg_data;
        REG_TEMP_LIMIT:   temp_lim_r  <= cfg_data[14:0];
        REG_PRESS_LIMIT:  press_lim_r <= cfg_data[10:0];
        REG_HUM_LIMIT:    hum_lim_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Calibration fields, sign-extended where the scheme treats them as signed.
  logic [15:0] t1;
  logic [31:0] t2, t3;
  logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h5, h6;
  logic [11:0] h4;

  assign t1 = cal_t_r[15:0];
  assign t2 = {{16{cal_t_r[31]}}, cal_t_r[31:16]};
  assign t3 = {{16{cal_t_r[47]}}, cal_t_r[47:32]};
  assign p9 = cal_t_r[63:48];
  assign p1 = cal_pl_r[15:0];
  assign p2 = cal_pl_r[31:16];
  assign p3 = cal_pl_r[47:32];
  assign p4 = cal_pl_r[63:48];
  assign p5 = cal_ph_r[15:0];
  assign p6 = cal_ph_r[31:16];
  assign p7 = cal_ph_r[47:32];
  assign p8 = cal_ph_r[63:48];
  assign h1 = {24'd0, cal_h_r[7:0]};
  assign h2 = {{16{cal_h_r[23]}}, cal_h_r[23:8]};
  assign h3 = {24'd0, cal_h_r[31:24]};
  assign h4 = cal_h_r[43:32];
  assign h5 = {{20{cal_h_r[55]}}, cal_h_r[55:44]};
  assign h6 = {{24{cal_h_r[63]}}, cal_h_r[63:56]};

  // --------------------------------------------------------------------------
  // Valid line for the front stages (1..10)
  // --------------------------------------------------------------------------
  logic [10:1] fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      fv_r <= {fv_r[9:1], start && !busy};
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1-3: temperature and fine temperature
  // --------------------------------------------------------------------------
  logic [31:0] ta, tb;
  logic [31:0] s1_m1_r, s1_bb_r;
  logic [19:0] s1_rp_r;
  logic [15:0] s1_rh_r;
  logic [31:0] s2_v1_r, s2_m2_r;
  logic [19:0] s2_rp_r;
  logic [15:0] s2_rh_r;
  logic [31:0] s3_tf_r;
  logic [19:0] s3_rp_r;
  logic [15:0] s3_rh_r;

  assign ta = {15'd0, in_raw_temp[19:3]} - {15'd0, t1, 1'b0};
  assign tb = {16'd0, in_raw_temp[19:4]} - {16'd0, t1};

  always_ff @(posedge clk) begin
    s1_m1_r <= ta * t2;
    s1_bb_r <= tb * tb;
    s1_rp_r <= in_raw_press;
    s1_rh_r <= in_raw_hum;
    s2_v1_r <= asr32(s1_m1_r, 11);
    s2_m2_r <= asr32(s1_bb_r, 12) * t3;
    s2_rp_r <= s1_rp_r;
    s2_rh_r <= s1_rh_r;
    s3_tf_r <= s2_v1_r + asr32(s2_m2_r, 14);
    s3_rp_r <= s2_rp_r;
    s3_rh_r <= s2_rh_r;
  end

  // --------------------------------------------------------------------------
  // Stage 4: temperature result and offsets for pressure and humidity
  // --------------------------------------------------------------------------
  logic [31:0] s4_temp_r, s4_hv_r;
  logic [33:0] s4_q1_r;
  logic [19:0] s4_rp_r;
  logic [15:0] s4_rh_r;

  always_ff @(posedge clk) begin
    s4_temp_r <= asr32({s3_tf_r[29:0], 2'b00} + s3_tf_r + 32'd128, 8);
    s4_q1_r   <= {{2{s3_tf_r[31]}}, s3_tf_r} - T_FINE_OFS_P;
    s4_hv_r   <= s3_tf_r - T_FINE_OFS_H;
    s4_rp_r   <= s3_rp_r;
    s4_rh_r   <= s3_rh_r;
  end

  // --------------------------------------------------------------------------
  // Stages 5-11: pressure numerator and divisor, humidity
  // --------------------------------------------------------------------------
  logic [63:0] s5_qq_r, s5_q1p5_r, s5_q1p2_r;
  logic [31:0] s5_mh5_r, s5_mh6_r, s5_mh3_r;
  logic [63:0] s6_q2a_r, s6_q1b_r, s6_q1p5_r, s6_q1p2_r;
  logic [31:0] s6_x_r, s6_myz_r;
  logic [63:0] s7_q2_r, s7_q1c_r;
  logic [31:0] s7_x_r, s7_my2_r;
  logic [63:0] s8_pd_r, s8_q2_r;
  logic [31:0] s8_vv_r;
  logic [63:0] s9_den_r, s9_diff_r;
  logic [31:0] s9_vv_r, s9_ss_r;
  logic [63:0] s10_num_r, s10_den_r;
  logic [31:0] s10_vv_r, s10_mm_r;
  logic [31:0] s5_temp_r, s6_temp_r, s7_temp_r, s8_temp_r, s9_temp_r, s10_temp_r;
  logic [19:0] s5_rp_r, s6_rp_r, s7_rp_r, s8_rp_r;
  logic [15:0] s5_rh_r;
  logic [31:0] hx, hy0, hz, hy1, hy2, hs, hv2;
  logic [63:0] pv;

  assign hx  = asr32({2'b00, s5_rh_r, 14'd0} - {h4, 20'd0} - s5_mh5_r + 32'd16384, 15);
  assign hy0 = asr32(s5_mh6_r, 10);
  assign hz  = asr32(s5_mh3_r, 11) + 32'd32768;
  assign hy1 = asr32(s6_myz_r, 10) + H_OFS_Y;
  assign hy2 = asr32(s7_my2_r + 32'd8192, 14);
  assign hs  = asr32(s8_vv_r, 15);
  assign hv2 = s10_vv_r - asr32(s10_mm_r, 4);
  assign pv  = P_FULL_SCALE - {44'd0, s8_rp_r};

  always_ff @(posedge clk) begin
    // Stage 5
    s5_qq_r   <= 64'($signed(s4_q1_r) * $signed(s4_q1_r));
    s5_q1p5_r <= 64'($signed(s4_q1_r) * $signed(p5));
    s5_q1p2_r <= 64'($signed(s4_q1_r) * $signed(p2));
    s5_mh5_r  <= h5 * s4_hv_r;
    s5_mh6_r  <= s4_hv_r * h6;
    s5_mh3_r  <= s4_hv_r * h3;
    s5_temp_r <= s4_temp_r;
    s5_rp_r   <= s4_rp_r;
    s5_rh_r   <= s4_rh_r;
    // Stage 6
    s6_q2a_r  <= 64'($signed(s5_qq_r) * $signed(p6));
    s6_q1b_r  <= 64'($signed(s5_qq_r) * $signed(p3));
    s6_q1p5_r <= s5_q1p5_r;
    s6_q1p2_r <= s5_q1p2_r;
    s6_x_r    <= hx;
    s6_myz_r  <= hy0 * hz;
    s6_temp_r <= s5_temp_r;
    s6_rp_r   <= s5_rp_r;
    // Stage 7
    s7_q2_r   <= s6_q2a_r + {s6_q1p5_r[46:0], 17'd0}
                 + {{13{p4[15]}}, p4, 35'd0};
    s7_q1c_r  <= asr64(s6_q1b_r, 8) + {s6_q1p2_r[51:0], 12'd0};
    s7_x_r    <= s6_x_r;
    s7_my2_r  <= hy1 * h2;
    s7_temp_r <= s6_temp_r;
    s7_rp_r   <= s6_rp_r;
    // Stage 8
    s8_pd_r   <= (s7_q1c_r + P_BIAS) * {48'd0, p1};
    s8_q2_r   <= s7_q2_r;
    s8_vv_r   <= s7_x_r * hy2;
    s8_temp_r <= s7_temp_r;
    s8_rp_r   <= s7_rp_r;
    // Stage 9
    s9_den_r  <= asr64(s8_pd_r, 33);
    s9_diff_r <= {pv[32:0], 31'd0} - s8_q2_r;
    s9_vv_r   <= s8_vv_r;
    s9_ss_r   <= hs * hs;
    s9_temp_r <= s8_temp_r;
    // Stage 10
    s10_num_r  <= s9_diff_r * P_SCALE;
    s10_den_r  <= s9_den_r;
    s10_vv_r   <= s9_vv_r;
    s10_mm_r   <= asr32(s9_ss_r, 7) * h1;
    s10_temp_r <= s9_temp_r;
  end

  // Stage 11 clamps humidity and feeds the divider with magnitudes.
  logic [16:0] hum_c;

  always_comb begin
    priority if (hv2[31]) begin
      hum_c = '0;
    end else if (hv2 > H_MAX) begin
      hum_c = H_MAX[28:12];
    end else begin
      hum_c = hv2[28:12];
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [63:0] dq_r   [0:DIV_STAGES];
  logic [63:0] drem_r [0:DIV_STAGES];
  logic [63:0] dd_r   [0:DIV_STAGES];
  logic [31:0] dtemp_r[0:DIV_STAGES];
  logic [16:0] dhum_r [0:DIV_STAGES];
  logic        dneg_r [0:DIV_STAGES];
  logic        dz_r   [0:DIV_STAGES];
  logic        dv_r   [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    dq_r[0]    <= s10_num_r[63] ? (64'd0 - s10_num_r) : s10_num_r;
    dd_r[0]    <= s10_den_r[63] ? (64'd0 - s10_den_r) : s10_den_r;
    drem_r[0]  <= '0;
    dneg_r[0]  <= s10_num_r[63] ^ s10_den_r[63];
    dz_r[0]    <= (s10_den_r == 64'd0);
    dtemp_r[0] <= s10_temp_r;
    dhum_r[0]  <= hum_c;
  end

  // Valid bit of stage 11, beside the divider inputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= fv_r[10];
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;

    assign rem_sh  = {drem_r[k-1], dq_r[k-1][63]};
    assign rem_sub = rem_sh - {1'b0, dd_r[k-1]};

    // Subtract when the shifted remainder covers the divisor.
    always_ff @(posedge clk) begin
      if (!rem_sub[64]) begin
        drem_r[k] <= rem_sub[63:0];
        dq_r[k]   <= {dq_r[k-1][62:0], 1'b1};
      end else begin
        drem_r[k] <= rem_sh[63:0];
        dq_r[k]   <= {dq_r[k-1][62:0], 1'b0};
      end
      dd_r[k]    <= dd_r[k-1];
      dneg_r[k]  <= dneg_r[k-1];
      dz_r[k]    <= dz_r[k-1];
      dtemp_r[k] <= dtemp_r[k-1];
      dhum_r[k]  <= dhum_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else begin
        dv_r[k] <= dv_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stages: sign, second-order terms, hPa and alarms
  // --------------------------------------------------------------------------
  logic [5:1]  pv_r;
  logic [63:0] o1_p_r, o2_p_r, o2_m9_r, o2_m8_r;
  logic [31:0] o3_press_r, o4_press_r;
  logic [49:0] o4_prod_r;
  logic [31:0] o1_temp_r, o2_temp_r, o3_temp_r, o4_temp_r;
  logic [16:0] o1_hum_r, o2_hum_r, o3_hum_r, o4_hum_r;
  logic        o1_dz_r, o2_dz_r;
  logic [63:0] psum, pfin;
  logic [17:0] hpa;

  assign psum = o2_p_r + asr64(o2_m9_r, 25) + asr64(o2_m8_r, 19);
  assign pfin = asr64(psum, 8) + {{44{p7[15]}}, p7, 4'd0};
  assign hpa  = o4_prod_r[49:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[4:1], dv_r[DIV_STAGES]};
    end
  end

  always_ff @(posedge clk) begin
    o1_p_r     <= dneg_r[DIV_STAGES] ? (64'd0 - dq_r[DIV_STAGES]) : dq_r[DIV_STAGES];
    o1_dz_r    <= dz_r[DIV_STAGES];
    o1_temp_r  <= dtemp_r[DIV_STAGES];
    o1_hum_r   <= dhum_r[DIV_STAGES];
    o2_p_r     <= o1_p_r;
    o2_m9_r    <= 64'($signed(p9) * $signed(asr64(o1_p_r, 13)));
    o2_m8_r    <= 64'($signed(p8) * $signed(o1_p_r));
    o2_dz_r    <= o1_dz_r;
    o2_temp_r  <= o1_temp_r;
    o2_hum_r   <= o1_hum_r;
    o3_press_r <= o2_dz_r ? 32'd0 : pfin[31:0];
    o3_temp_r  <= o2_temp_r;
    o3_hum_r   <= o2_hum_r;
    // Whole hPa is (Pa in Q24.8 >> 8) / 100 through the reciprocal.
    o4_prod_r  <= o3_press_r[31:8] * RECIP_100;
    o4_press_r <= o3_press_r;
    o4_temp_r  <= o3_temp_r;
    o4_hum_r   <= o3_hum_r;
  end

  // Result register.
  always_ff @(posedge clk) begin
    out_temp_centi  <= o4_temp_r;
    out_press_q24_8 <= o4_press_r;
    out_press_hpa   <= hpa;
    out_hum_q22_10  <= o4_hum_r;
    out_temp_alarm  <= $signed(o4_temp_r) > $signed({{17{temp_lim_r[14]}}, temp_lim_r});
    out_press_alarm <= hpa < {7'd0, press_lim_r};
    out_hum_alarm   <= o4_hum_r[16:10] > hum_lim_r;
  end

  assign out_valid = pv_r[5];

`ifndef SYNTHESIS
  // Humidity never leaves the clamped range.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hum_q22_10 <= 17'd102400))
    else $error("humidity beyond clamp");

  // Reciprocal division stays within the hPa range.
  a_hpa_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_press_hpa <= 18'd167772))
    else $error("hPa out of range");

  // Pressure below one hPa gives zero whole hPa.
  a_hpa_small: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_press_q24_8 < 32'd25600)) |-> (out_press_hpa == 18'd0))
    else $error("hPa division wrong for small pressure");

  // A zero divisor leaving the divider yields zero pressure two stages on.
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r[1] && o1_dz_r) |=> ##1 (o3_press_r == 32'd0))
    else $error("zero divisor did not zero pressure");
`endif

endmodule
